// File: rtl/qts_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qts_pkg: shared types and constants for the quoted token splitter
// Byte type, phase encoding and the character codes used by the parser.
// ---------------------------------------------------------------------------
package qts_pkg;

	typedef logic [7:0] byte_t;

	// parser phase, one-hot
	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_QUOTED = 4'b0010,
		PH_ESCAPE = 4'b0100,
		PH_BARE   = 4'b1000
	} phase_t;

	localparam byte_t CH_NUL    = 8'h00;
	localparam byte_t CH_DQUOTE = 8'h22;
	localparam byte_t CH_SQUOTE = 8'h27;
	localparam byte_t CH_QMARK  = 8'h3F;
	localparam byte_t CH_BSLASH = 8'h5C;
	localparam byte_t CH_GR_LO  = 8'h21;
	localparam byte_t CH_GR_HI  = 8'h7E;

	// escape letters and the control codes they stand for
	localparam byte_t CH_A = 8'h61;
	localparam byte_t CH_B = 8'h62;
	localparam byte_t CH_F = 8'h66;
	localparam byte_t CH_N = 8'h6E;
	localparam byte_t CH_R = 8'h72;
	localparam byte_t CH_T = 8'h74;
	localparam byte_t CH_V = 8'h76;

	localparam byte_t CC_BEL = 8'h07;
	localparam byte_t CC_BS  = 8'h08;
	localparam byte_t CC_HT  = 8'h09;
	localparam byte_t CC_LF  = 8'h0A;
	localparam byte_t CC_VT  = 8'h0B;
	localparam byte_t CC_FF  = 8'h0C;
	localparam byte_t CC_CR  = 8'h0D;

	function automatic logic is_graphic(input byte_t c);
		return (c >= CH_GR_LO) && (c <= CH_GR_HI);
	endfunction

endpackage
`default_nettype wire

// File: rtl/qts_in_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qts_in_if: input byte channel
// Valid/ready channel carrying one text byte per transfer.
// ---------------------------------------------------------------------------
interface qts_in_if;
	logic           valid;
	logic           ready;
	qts_pkg::byte_t in_char;

	modport source (output valid, output in_char, input ready);
	modport sink   (input valid, input in_char, output ready);
endinterface
`default_nettype wire

// File: rtl/qts_out_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qts_out_if: token output channel
// Valid/ready channel carrying one decoded byte or an end-of-token marker.
// ---------------------------------------------------------------------------
interface qts_out_if;
	logic           valid;
	logic           ready;
	qts_pkg::byte_t out_char;
	logic           token_done;
	logic           escape_flag;

	modport source (output valid, output out_char, output token_done,
		output escape_flag, input ready);
	modport sink   (input valid, input out_char, input token_done,
		input escape_flag, output ready);
endinterface
`default_nettype wire

// File: rtl/quoted_token_splitter.sv
`default_nettype none
// ---------------------------------------------------------------------------
// quoted_token_splitter: byte stream tokenizer with quoted strings
// Splits text into bare tokens and quoted strings, decodes C escapes inside
// quotes and marks the end of each token with a separate transfer.
// ---------------------------------------------------------------------------
//  channel   dir  payload                              handshake
//  in        in   in_char[7:0]                         valid/ready
//  out       out  out_char[7:0], token_done, escape_flag  valid/ready
//
//  One byte per cycle sustained while out accepts; each result passes
//  the input register, then the result register, before it is offered on out.
//  The phase and quote-kind registers form the only loop: one small decode per byte.
//  Bytes that produce no result retire without waiting on the output.
//  Output stalls back up through the input register to in.ready.
//  arst_n clears phase, quote kind and both valid flags.
// ---------------------------------------------------------------------------
module quoted_token_splitter (
	input  wire            clk,
	input  wire            arst_n,
	qts_in_if.sink         in,
	qts_out_if.source      out
);

	// input register
	logic           valid_s1;
	qts_pkg::byte_t char_s1;

	// parser state
	qts_pkg::phase_t phase_q;
	logic            single_q;

	// result register
	logic           valid_s2;
	qts_pkg::byte_t char_s2;
	logic           done_s2;
	logic           flag_s2;

	// next-state and result decode
	qts_pkg::phase_t phase_d;
	logic            single_d;
	logic            has_res;
	qts_pkg::byte_t  res_char;
	logic            res_done;
	logic            res_flag;
	logic            out_free;
	logic            adv_s1;
	qts_pkg::byte_t  closing;

	always_comb begin
		phase_d  = phase_q;
		single_d = single_q;
		has_res  = 1'b0;
		res_char = qts_pkg::CH_NUL;
		res_done = 1'b0;
		res_flag = 1'b0;
		closing  = single_q ? qts_pkg::CH_SQUOTE : qts_pkg::CH_DQUOTE;
		unique case (phase_q)
			qts_pkg::PH_IDLE: begin
				if (qts_pkg::is_graphic(char_s1)) begin
					if (char_s1 == qts_pkg::CH_DQUOTE) begin
						single_d = 1'b0;
						phase_d  = qts_pkg::PH_QUOTED;
					end else if (char_s1 == qts_pkg::CH_SQUOTE) begin
						single_d = 1'b1;
						phase_d  = qts_pkg::PH_QUOTED;
					end else begin
						phase_d  = qts_pkg::PH_BARE;
						has_res  = 1'b1;
						res_char = char_s1;
					end
				end
			end
			qts_pkg::PH_QUOTED: begin
				if (char_s1 == qts_pkg::CH_NUL || char_s1 == closing) begin
					phase_d  = qts_pkg::PH_IDLE;
					has_res  = 1'b1;
					res_done = 1'b1;
				end else if (char_s1 == qts_pkg::CH_BSLASH) begin
					phase_d = qts_pkg::PH_ESCAPE;
				end else begin
					has_res  = 1'b1;
					res_char = char_s1;
				end
			end
			qts_pkg::PH_ESCAPE: begin
				has_res = 1'b1;
				if (char_s1 == qts_pkg::CH_NUL) begin
					phase_d  = qts_pkg::PH_IDLE;
					res_done = 1'b1;
				end else begin
					phase_d = qts_pkg::PH_QUOTED;
					case (char_s1) inside
						qts_pkg::CH_A: res_char = qts_pkg::CC_BEL;
						qts_pkg::CH_B: res_char = qts_pkg::CC_BS;
						qts_pkg::CH_F: res_char = qts_pkg::CC_FF;
						qts_pkg::CH_N: res_char = qts_pkg::CC_LF;
						qts_pkg::CH_R: res_char = qts_pkg::CC_CR;
						qts_pkg::CH_T: res_char = qts_pkg::CC_HT;
						qts_pkg::CH_V: res_char = qts_pkg::CC_VT;
						qts_pkg::CH_BSLASH, qts_pkg::CH_SQUOTE,
						qts_pkg::CH_DQUOTE, qts_pkg::CH_QMARK: res_char = char_s1;
						default: begin
							res_char = char_s1;
							res_flag = 1'b1;
						end
					endcase
				end
			end
			qts_pkg::PH_BARE: begin
				has_res = 1'b1;
				if (qts_pkg::is_graphic(char_s1)) begin
					res_char = char_s1;
				end else begin
					phase_d  = qts_pkg::PH_IDLE;
					res_done = 1'b1;
				end
			end
			default: begin
				phase_d = qts_pkg::PH_IDLE;
			end
		endcase
	end

	// pipeline flow control
	assign out_free = !valid_s2 || out.ready;
	assign adv_s1   = valid_s1 && (!has_res || out_free);
	assign in.ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.ready && in.valid) begin
			char_s1 <= in.in_char;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= qts_pkg::PH_IDLE;
			single_q <= 1'b0;
		end else if (adv_s1) begin
			phase_q  <= phase_d;
			single_q <= single_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv_s1 && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_res) begin
			char_s2 <= res_char;
			done_s2 <= res_done;
			flag_s2 <= res_flag;
		end
	end

	assign out.valid       = valid_s2;
	assign out.out_char    = char_s2;
	assign out.token_done  = done_s2;
	assign out.escape_flag = flag_s2;

`ifndef ASSERT_OFF
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("phase register lost one-hot encoding");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && done_s2) |-> (char_s2 == qts_pkg::CH_NUL && !flag_s2))
		else $error("end marker carries a byte or a flag");

	a_flag_from_escape: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && has_res && res_flag) |-> (phase_q == qts_pkg::PH_ESCAPE))
		else $error("escape flag raised outside an escape");

	a_escape_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && phase_q == qts_pkg::PH_ESCAPE)
		|=> (phase_q == qts_pkg::PH_QUOTED || phase_q == qts_pkg::PH_IDLE))
		else $error("escape did not return to a string or idle");

	a_bare_start: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && phase_q == qts_pkg::PH_IDLE && has_res)
		|=> (phase_q == qts_pkg::PH_BARE && valid_s2 && !done_s2))
		else $error("emitted byte from idle did not open a bare token");
`endif

endmodule
`default_nettype wire
